### rtl/nnsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsa_pkg: shared definitions for the nearest-neighbor scale address unit
// Field widths, configuration register indexes, default parameter values and
// the one-bit restoring divide step.
// ----------------------------------------------------------------------------
package nnsa_pkg;

  localparam int DIM_CFG_W  = 13;   // src_width / src_height registers
  localparam int ZOOM_W     = 15;   // zoom_x / zoom_y registers
  localparam int COORD_W    = 14;   // out_row / out_col
  localparam int SRC_OFF_W  = 26;
  localparam int DST_OFF_W  = 30;
  localparam int SCALED_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int BPP_W      = 2;

  localparam int DEF_MAX_SRC_DIM    = 4096;
  localparam int DEF_MAX_OUT_DIM    = 16384;
  localparam int DEF_ZOOM_FRAC_BITS = 8;

  localparam logic [DIM_CFG_W-1:0] RST_SRC_DIM = DIM_CFG_W'(1);
  localparam logic [ZOOM_W-1:0]    RST_ZOOM    = ZOOM_W'(256);
  localparam logic [BPP_W-1:0]     BPP_8       = BPP_W'(1);
  localparam logic [BPP_W-1:0]     BPP_24      = BPP_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_MODE       = 3'd2,
    REG_ZOOM_X     = 3'd3,
    REG_ZOOM_Y     = 3'd4
  } cfg_reg_t;

  // One restoring step: shift in a dividend bit, subtract when it fits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [ZOOM_W:0] div_step(input logic [ZOOM_W-1:0] rem,
                                               input logic              num_bit,
                                               input logic [ZOOM_W-1:0] dvsr);
    logic [ZOOM_W:0] shifted;
    logic [ZOOM_W:0] diff;
    shifted = {rem, num_bit};
    diff    = shifted - {1'b0, dvsr};
    if (shifted >= {1'b0, dvsr}) begin
      div_step = {1'b1, diff[ZOOM_W-1:0]};
    end else begin
      div_step = {1'b0, shifted[ZOOM_W-1:0]};
    end
  endfunction

endpackage

### rtl/nearest_neighbor_scale_address_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_top: nearest-neighbor scaler address unit
// Maps each output pixel coordinate to the byte offsets of its nearest source
// pixel and of itself in 4-byte padded, bottom-up 8/24-bit bitmaps.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | in_valid / in_ready    | out_row, out_col
//   out     | output    | out_valid / out_ready  | in_range, src/dst offset, size
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle sustained while the skid entry is empty. The pipeline has
// one stage per quotient bit of the two restoring dividers, one multiply
// stage and one output register.
// Reset is synchronous; configuration returns to 1x1, 8 bpp, zoom 1.0.
// Derived sizes and strides pass through product, size and stride registers.
// A two-entry output (register plus skid) lets in_ready come from a flop;
// a stall freezes the whole pipeline.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_top #(
  parameter int MAX_SRC_DIM    = nnsa_pkg::DEF_MAX_SRC_DIM,
  parameter int MAX_OUT_DIM    = nnsa_pkg::DEF_MAX_OUT_DIM,
  parameter int ZOOM_FRAC_BITS = nnsa_pkg::DEF_ZOOM_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input coordinates
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [nnsa_pkg::COORD_W-1:0]       in_out_row,
  input  logic [nnsa_pkg::COORD_W-1:0]       in_out_col,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_in_range,
  output logic [nnsa_pkg::SRC_OFF_W-1:0]     out_src_offset,
  output logic [nnsa_pkg::DST_OFF_W-1:0]     out_dst_offset,
  output logic [nnsa_pkg::SCALED_W-1:0]      out_scaled_width,
  output logic [nnsa_pkg::SCALED_W-1:0]      out_scaled_height
);
  import nnsa_pkg::*;

  localparam int NW      = COORD_W + ZOOM_FRAC_BITS;          // dividend / quotient bits
  localparam int SRC_W   = $clog2(MAX_SRC_DIM + 1);
  localparam int OUT_W   = $clog2(MAX_OUT_DIM + 1);
  localparam int SPROD_W = SRC_W + ZOOM_W;
  localparam int SSTR_W  = SRC_W + 2;
  localparam int DSTR_W  = OUT_W + 2;
  localparam int SROW_W  = SRC_W + SSTR_W;
  localparam int DROW_W  = COORD_W + DSTR_W;
  localparam int COLB_W  = COORD_W + BPP_W;
  localparam int SCOLB_W = SRC_W + BPP_W;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [ZOOM_W-1:0]  rem_row;
    logic [ZOOM_W-1:0]  rem_col;
    logic [NW-1:0]      q_row;
    logic [NW-1:0]      q_col;
  } div_stage_t;

  typedef struct packed {
    logic                 in_range;
    logic [SRC_OFF_W-1:0] src_offset;
    logic [DST_OFF_W-1:0] dst_offset;
  } result_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_CFG_W-1:0] src_width_r, src_height_r;
  logic                 mode_r;
  logic [ZOOM_W-1:0]    zoom_x_r, zoom_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_DIM;
      src_height_r <= RST_SRC_DIM;
      mode_r       <= 1'b0;
      zoom_x_r     <= RST_ZOOM;
      zoom_y_r     <= RST_ZOOM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width_r  <= cfg_data[DIM_CFG_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_data[DIM_CFG_W-1:0];
        REG_MODE:       mode_r       <= cfg_data[0];
        REG_ZOOM_X:     zoom_x_r     <= cfg_data[ZOOM_W-1:0];
        REG_ZOOM_Y:     zoom_y_r     <= cfg_data[ZOOM_W-1:0];
        default:        ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // derived geometry: sizes and strides, three register steps
  // --------------------------------------------------------------------------
  logic [SRC_W-1:0]   src_w_clamp, src_h_clamp;
  logic [BPP_W-1:0]   bpp;
  logic [SRC_W+2:0]   src_bytes;
  logic [SPROD_W-1:0] prod_w_r, prod_h_r;
  logic [SSTR_W-1:0]  src_stride_r;
  logic [SPROD_W-1:0] shift_w, shift_h;
  logic [OUT_W-1:0]   nw_r, nh_r;
  logic [OUT_W+2:0]   dst_bytes;
  logic [DSTR_W-1:0]  dst_stride_r;

  assign src_w_clamp = (src_width_r > MAX_SRC_DIM) ? SRC_W'(MAX_SRC_DIM) : SRC_W'(src_width_r);
  assign src_h_clamp = (src_height_r > MAX_SRC_DIM) ? SRC_W'(MAX_SRC_DIM)
                                                    : SRC_W'(src_height_r);
  assign bpp         = mode_r ? BPP_24 : BPP_8;
  assign src_bytes   = (SRC_W+3)'(src_w_clamp) * (SRC_W+3)'(bpp) + (SRC_W+3)'(3);
  assign shift_w     = prod_w_r >> ZOOM_FRAC_BITS;
  assign shift_h     = prod_h_r >> ZOOM_FRAC_BITS;
  assign dst_bytes   = (OUT_W+3)'(nw_r) * (OUT_W+3)'(bpp) + (OUT_W+3)'(3);

  always_ff @(posedge clk) begin
    prod_w_r     <= SPROD_W'(src_w_clamp) * SPROD_W'(zoom_x_r);
    prod_h_r     <= SPROD_W'(src_h_clamp) * SPROD_W'(zoom_y_r);
    // round bytes up to a multiple of four
    src_stride_r <= SSTR_W'({src_bytes[SRC_W+2:2], 2'b00});
    nw_r         <= (shift_w > MAX_OUT_DIM) ? OUT_W'(MAX_OUT_DIM) : OUT_W'(shift_w);
    nh_r         <= (shift_h > MAX_OUT_DIM) ? OUT_W'(MAX_OUT_DIM) : OUT_W'(shift_h);
    dst_stride_r <= DSTR_W'({dst_bytes[OUT_W+2:2], 2'b00});
  end

  // --------------------------------------------------------------------------
  // divider pipeline: one quotient bit of row and of col per stage
  // --------------------------------------------------------------------------
  logic       skid_valid_r;
  logic       pipe_en;
  div_stage_t div_r   [NW];
  div_stage_t div_nxt [NW];

  assign pipe_en  = !skid_valid_r;
  assign in_ready = pipe_en;

  always_comb begin
    div_stage_t      prev;
    logic [NW-1:0]   num_row, num_col;
    logic [ZOOM_W:0] step_row, step_col;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        prev         = '0;
        prev.valid   = in_valid;
        prev.row     = in_out_row;
        prev.col     = in_out_col;
      end else begin
        prev = div_r[s-1];
      end
      num_row  = {prev.row, {ZOOM_FRAC_BITS{1'b0}}};
      num_col  = {prev.col, {ZOOM_FRAC_BITS{1'b0}}};
      step_row = div_step(prev.rem_row, num_row[NW-1-s], zoom_y_r);
      step_col = div_step(prev.rem_col, num_col[NW-1-s], zoom_x_r);
      div_nxt[s]         = prev;
      div_nxt[s].rem_row = step_row[ZOOM_W-1:0];
      div_nxt[s].rem_col = step_col[ZOOM_W-1:0];
      div_nxt[s].q_row   = {prev.q_row[NW-2:0], step_row[ZOOM_W]};
      div_nxt[s].q_col   = {prev.q_col[NW-2:0], step_col[ZOOM_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NW; s++) begin
        div_r[s].valid <= 1'b0;
      end
    end else if (pipe_en) begin
      div_r <= div_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // multiply stage
  // --------------------------------------------------------------------------
  div_stage_t         tail;
  logic               mul_valid_r;
  logic               mul_in_range_r;
  logic [SROW_W-1:0]  src_row_part_r;
  logic [SCOLB_W-1:0] src_col_part_r;
  logic [DROW_W-1:0]  dst_row_part_r;
  logic [COLB_W-1:0]  dst_col_part_r;
  logic [SRC_W-1:0]   src_row, src_col;

  assign tail = div_r[NW-1];
  // inside the scaled image the quotient is below the source size
  assign src_row = SRC_W'(tail.q_row);
  assign src_col = SRC_W'(tail.q_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (pipe_en) begin
      mul_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mul_in_range_r <= (tail.row < nh_r) && (tail.col < nw_r);
      src_row_part_r <= SROW_W'(src_row) * SROW_W'(src_stride_r);
      src_col_part_r <= SCOLB_W'(src_col) * SCOLB_W'(bpp);
      dst_row_part_r <= DROW_W'(tail.row) * DROW_W'(dst_stride_r);
      dst_col_part_r <= COLB_W'(tail.col) * COLB_W'(bpp);
    end
  end

  // --------------------------------------------------------------------------
  // final add, output register and skid entry
  // --------------------------------------------------------------------------
  result_t res_nxt, out_r, skid_r;
  logic    out_valid_r;
  logic    out_load;
  logic    [SROW_W:0] src_sum;
  logic    [DROW_W:0] dst_sum;

  assign src_sum = (SROW_W+1)'(src_row_part_r) + (SROW_W+1)'(src_col_part_r);
  assign dst_sum = (DROW_W+1)'(dst_row_part_r) + (DROW_W+1)'(dst_col_part_r);

  always_comb begin
    res_nxt          = '0;
    res_nxt.in_range = mul_in_range_r;
    if (mul_in_range_r) begin
      res_nxt.src_offset = SRC_OFF_W'(src_sum);
      res_nxt.dst_offset = DST_OFF_W'(dst_sum);
    end
  end

  assign out_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= mul_valid_r;
      end
    end else if (mul_valid_r && pipe_en) begin
      // hold the arriving word while the output waits
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end
    if (!out_load && pipe_en) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_in_range      = out_r.in_range;
  assign out_src_offset    = out_r.src_offset;
  assign out_dst_offset    = out_r.dst_offset;
  assign out_scaled_width  = SCALED_W'(nw_r);
  assign out_scaled_height = SCALED_W'(nh_r);

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a word while the output register is empty");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_src_offset == '0 && out_dst_offset == '0))
    else $error("out-of-range word carries a nonzero offset");

  a_inside_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |-> (out_scaled_width != '0 && out_scaled_height != '0))
    else $error("in-range word reported for an empty scaled image");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_valid_r && $past(rst_n) && !$past(skid_valid_r) && skid_valid_r == 1'b0) ||
    !$rose(skid_valid_r) || $past(out_valid_r && !out_ready))
    else $error("skid entry filled while the output was free");

endmodule
